@@ src/mixed_block_heap_allocator_macros.svh @@
// Assertion helpers shared by the allocator RTL.
`ifndef MIXED_BLOCK_HEAP_ALLOCATOR_MACROS_SVH
`define MIXED_BLOCK_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while rst_n is low.
`define MBHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, muted while rst_n is low.
`define MBHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mbha_pkg.sv @@
`timescale 1ns / 1ps
package mbha_pkg;

  localparam int SIZE_W  = 16;
  localparam int MASK_W  = 40;
  localparam int ADDR_W  = 32;
  localparam int ENTRY_W = 6;
  localparam int CODE_W  = 5;
  localparam int NEED_W  = 3;

  // map entry codes
  localparam logic [CODE_W-1:0] CODE_FREE  = 5'd0;
  localparam logic [CODE_W-1:0] CODE_SMALL = 5'd1;
  localparam logic [CODE_W-1:0] CODE_PAIR  = 5'd2;
  localparam logic [CODE_W-1:0] CODE_CONT  = 5'd31;

  // request size classes
  localparam logic [SIZE_W-1:0] SMALL_MAX_BYTES = 16'd512;
  localparam logic [SIZE_W-1:0] KB_BYTES        = 16'd1024;
  localparam logic [SIZE_W-1:0] PAIR_MAX_BYTES  = 16'd1536;
  localparam logic [SIZE_W-1:0] RUN_MAX_BYTES   = 16'd7168;

  // fixed layout landmarks
  localparam logic [ENTRY_W-1:0] SMALL_FIRST    = 6'd0;
  localparam logic [ENTRY_W-1:0] SMALL_LO_LAST  = 6'd6;
  localparam logic [ENTRY_W-1:0] SMALL_HI_FIRST = 6'd16;
  localparam logic [ENTRY_W-1:0] SMALL_HI_LAST  = 6'd30;
  localparam logic [ENTRY_W-1:0] KB_LO_FIRST    = 6'd9;
  localparam logic [ENTRY_W-1:0] KB_LO_LAST     = 6'd14;
  localparam logic [ENTRY_W-1:0] KB_HI_FIRST    = 6'd33;
  localparam logic [ENTRY_W-1:0] KB_HI_LAST     = 6'd39;

  localparam logic [1:0] PAIR_HEAD_LAST = 2'd2;

  localparam logic [ADDR_W-1:0] BASE_SMALL_LO = 32'h2000_1000;
  localparam logic [ADDR_W-1:0] BASE_KB_LO    = 32'h2000_2000;
  localparam logic [ADDR_W-1:0] BASE_SMALL_HI = 32'h2000_4000;
  localparam logic [ADDR_W-1:0] BASE_KB_HI    = 32'h2000_6000;

  function automatic logic [ENTRY_W-1:0] pair_head(input logic [1:0] idx);
    logic [ENTRY_W-1:0] h;
    unique case (idx)
      2'd0:    h = 6'd7;
      2'd1:    h = 6'd15;
      default: h = 6'd31;
    endcase
    return h;
  endfunction

  function automatic logic [ADDR_W-1:0] entry_address(input logic [ENTRY_W-1:0] s);
    logic [ADDR_W-1:0] a;
    if (s < 6'd8) begin
      a = BASE_SMALL_LO + (ADDR_W'(s[2:0]) << 9);
    end else if (s < 6'd16) begin
      a = BASE_KB_LO + (ADDR_W'(s[2:0]) << 10);
    end else if (s < 6'd32) begin
      a = BASE_SMALL_HI + (ADDR_W'(s[3:0]) << 9);
    end else begin
      a = BASE_KB_HI + (ADDR_W'(s[2:0]) << 10);
    end
    return a;
  endfunction

endpackage

@@ src/mbha_ram.sv @@
`timescale 1ns / 1ps
module mbha_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/mixed_block_heap_allocator.sv @@
`timescale 1ns / 1ps
// Heap block allocator over a 40-entry map of 512-byte and 1 KB SRAM blocks.
// One request is taken at a time; in_tready stays low until its result word
// has been taken. A small sequencer probes one map entry at a time, a read
// state then a check state per entry, through the single read port of the map
// RAM, then writes one claimed entry per cycle. A small request that falls
// through to the 1 KB run search probes 22 small and 13 run entries. Sizes
// above 7168 bytes fail without a probe. Failure returns address zero with
// out_tuser set and the mask unchanged. The map is free after reset; blocks
// are never released.
`include "mixed_block_heap_allocator_macros.svh"
module mixed_block_heap_allocator #(
  parameter int MAP_ENTRIES = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // request_bytes[15:0], mask_in[55:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // block_address[31:0], start_entry[37:32],
                                  // mask_out[77:38], zero fill[79:78]
  output logic        out_tuser   // failed
);

  import mbha_pkg::*;

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_WRITE, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_SMALL, M_PAIR, M_RUN
  } mode_t;

  state_t              state_r;
  mode_t               mode_r;
  logic [ENTRY_W-1:0]  cur_r;
  logic [ENTRY_W-1:0]  start_r;
  logic [ENTRY_W-1:0]  wr_ptr_r;
  logic [NEED_W-1:0]   need_r;
  logic [NEED_W-1:0]   run_r;
  logic [NEED_W-1:0]   count_r;
  logic [1:0]          head_idx_r;
  logic                second_r;
  logic [CODE_W-1:0]   head_code_r;
  logic [MASK_W-1:0]   mask_r;
  logic [MAP_ENTRIES-1:0] valid_r;

  logic [ADDR_W-1:0]   out_addr_r;
  logic [ENTRY_W-1:0]  out_start_r;
  logic [MASK_W-1:0]   out_mask_r;
  logic                out_failed_r;

  logic [SIZE_W-1:0]   req_bytes;
  logic [MASK_W-1:0]   req_mask;
  logic [NEED_W-1:0]   need_calc;
  logic                in_fire;
  logic                ram_we;
  logic [CODE_W-1:0]   ram_wdata;
  logic [CODE_W-1:0]   ram_rdata;
  logic                entry_free;
  logic [MASK_W-1:0]   wr_bit;
  logic [NEED_W-1:0]   run_inc;

  assign req_bytes = in_tdata[15:0];
  assign req_mask  = in_tdata[55:16];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // ceil(size / 1 KB); only used for sizes up to the run limit
  assign need_calc = NEED_W'((17'(req_bytes) + 17'(KB_BYTES) - 17'd1) >> 10);

  assign ram_we    = (state_r == S_WRITE);
  assign ram_wdata = (wr_ptr_r == start_r) ? head_code_r : CODE_CONT;
  assign wr_bit    = MASK_W'(1) << wr_ptr_r;
  assign run_inc   = run_r + NEED_W'(1);

  // an entry never written reads as free
  assign entry_free = !valid_r[cur_r[IDX_W-1:0]] || (ram_rdata == CODE_FREE);

  mbha_ram #(
    .WIDTH(CODE_W),
    .DEPTH(MAP_ENTRIES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r[IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(cur_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mask_r <= req_mask;
            priority if (req_bytes <= SMALL_MAX_BYTES) begin
              mode_r  <= M_SMALL;
              cur_r   <= SMALL_FIRST;
              state_r <= S_READ;
            end else if (req_bytes > KB_BYTES && req_bytes <= PAIR_MAX_BYTES) begin
              mode_r     <= M_PAIR;
              head_idx_r <= 2'd0;
              cur_r      <= pair_head(2'd0);
              second_r   <= 1'b0;
              state_r    <= S_READ;
            end else if (req_bytes > RUN_MAX_BYTES) begin
              out_addr_r   <= '0;
              out_start_r  <= '0;
              out_failed_r <= 1'b1;
              out_mask_r   <= req_mask;
              state_r      <= S_DONE;
            end else begin
              mode_r  <= M_RUN;
              need_r  <= need_calc;
              cur_r   <= KB_LO_FIRST;
              run_r   <= '0;
              state_r <= S_READ;
            end
          end
        end

        // wait for the registered map read
        S_READ: state_r <= S_CHECK;

        S_CHECK: begin
          unique case (mode_r)
            M_SMALL: begin
              priority if (entry_free) begin
                start_r     <= cur_r;
                wr_ptr_r    <= cur_r;
                head_code_r <= CODE_SMALL;
                count_r     <= NEED_W'(1);
                state_r     <= S_WRITE;
              end else if (cur_r == SMALL_HI_LAST) begin
                // no small block left: fall back to one 1 KB block
                mode_r  <= M_RUN;
                need_r  <= NEED_W'(1);
                cur_r   <= KB_LO_FIRST;
                run_r   <= '0;
                state_r <= S_READ;
              end else begin
                cur_r   <= (cur_r == SMALL_LO_LAST) ? SMALL_HI_FIRST : cur_r + 6'd1;
                state_r <= S_READ;
              end
            end

            M_PAIR: begin
              priority if (entry_free && second_r) begin
                start_r     <= cur_r - 6'd1;
                wr_ptr_r    <= cur_r - 6'd1;
                head_code_r <= CODE_PAIR;
                count_r     <= NEED_W'(2);
                state_r     <= S_WRITE;
              end else if (entry_free) begin
                cur_r    <= cur_r + 6'd1;
                second_r <= 1'b1;
                state_r  <= S_READ;
              end else if (head_idx_r == PAIR_HEAD_LAST) begin
                mode_r  <= M_RUN;
                need_r  <= NEED_W'(2);
                cur_r   <= KB_LO_FIRST;
                run_r   <= '0;
                state_r <= S_READ;
              end else begin
                head_idx_r <= head_idx_r + 2'd1;
                cur_r      <= pair_head(head_idx_r + 2'd1);
                second_r   <= 1'b0;
                state_r    <= S_READ;
              end
            end

            default: begin
              priority if (entry_free && run_inc == need_r) begin
                start_r     <= cur_r + 6'd1 - ENTRY_W'(need_r);
                wr_ptr_r    <= cur_r + 6'd1 - ENTRY_W'(need_r);
                head_code_r <= CODE_W'(need_r);
                count_r     <= need_r;
                state_r     <= S_WRITE;
              end else if (cur_r == KB_HI_LAST) begin
                out_addr_r   <= '0;
                out_start_r  <= '0;
                out_failed_r <= 1'b1;
                out_mask_r   <= mask_r;
                state_r      <= S_DONE;
              end else if (cur_r == KB_LO_LAST) begin
                // a run never crosses the gap between the two 1 KB ranges
                cur_r   <= KB_HI_FIRST;
                run_r   <= '0;
                state_r <= S_READ;
              end else begin
                cur_r   <= cur_r + 6'd1;
                run_r   <= entry_free ? run_inc : '0;
                state_r <= S_READ;
              end
            end
          endcase
        end

        S_WRITE: begin
          valid_r[wr_ptr_r[IDX_W-1:0]] <= 1'b1;
          mask_r   <= mask_r | wr_bit;
          wr_ptr_r <= wr_ptr_r + 6'd1;
          count_r  <= count_r - NEED_W'(1);
          if (count_r == NEED_W'(1)) begin
            out_addr_r   <= entry_address(start_r);
            out_start_r  <= start_r;
            out_failed_r <= 1'b0;
            out_mask_r   <= mask_r | wr_bit;
            state_r      <= S_DONE;
          end
        end

        default: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {2'b00, out_mask_r, out_start_r, out_addr_r};
  assign out_tuser  = out_failed_r;

  `MBHA_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready,
    "allocator took a second request")
  `MBHA_ASSERT_NOW(a_fail_zero, out_tvalid && out_tuser,
    (out_addr_r == '0) && (out_start_r == '0), "failed result carries an address")
  `MBHA_ASSERT_NOW(a_claim_in_mask, out_tvalid && !out_tuser, out_mask_r[out_start_r],
    "claimed start entry missing from mask")
  `MBHA_ASSERT_NOW(a_write_fresh, ram_we, !valid_r[wr_ptr_r[IDX_W-1:0]],
    "allocator overwrote a used map entry")

endmodule
